/* hdl/cpba_pkg.sv */
package cpba_pkg;

	localparam int WORD_BITS   = 64;
	localparam int TABLE_WORDS = 64;
	localparam int TOTAL_PAGES = WORD_BITS * TABLE_WORDS;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int ADDR_W      = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
	localparam int PW          = 16;   // holds node * area products and their area ends
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_PAGES = 1'd1;

	localparam logic [1:0] ACT_ACQUIRE = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_INSPECT = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD      = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  node;
		logic [11:0] page;
		logic [12:0] count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] first_page;
		logic        in_use;
		logic        continues_run;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_SCAN,
		S_MARK,
		S_DONE
	} state_t;

	// control from sequencer to the bitmap memory
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_BITS-1:0] wr_mask;
		logic              set;      // set run bits, else clear
		logic [WORD_BITS-1:0] cont_mask;
	} mem_ctl_t;

endpackage

/* hdl/contiguous_page_bitmap_allocator_unit.sv */
// channel  | signals                        | handshake
// ---------+--------------------------------+-------------------------------
// request  | start, busy, req (req_t)       | taken when start & !busy
// result   | done, rsp (rsp_t)              | one-cycle strobe, no stall
// config   | cfg_we, cfg_idx, cfg_data      | written when cfg_we is high
//
// busy stays high after the accept until the result strobe has been given;
// a release marks each word touched, an acquire reads and then checks each
// word scanned and then marks each word of the run found;
// the registered bitmap read is why each scanned word needs a read and a check.
// after reset a clearing pass over all TABLE_WORDS words keeps busy high.
// the result strobe cannot be held off; configuration is taken at any time.
module contiguous_page_bitmap_allocator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  cpba_pkg::req_t                     req,
	output logic                               done,
	output cpba_pkg::rsp_t                     rsp,
	input  logic                               cfg_we,
	input  logic [cpba_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [cpba_pkg::CFG_W-1:0]         cfg_data
);
	localparam int WB = cpba_pkg::WORD_BITS;
	localparam int PW = cpba_pkg::PW;
	localparam int BW = cpba_pkg::BIT_W;
	localparam int AW = cpba_pkg::ADDR_W;

	cpba_pkg::state_t state_q, state_d;
	cpba_pkg::req_t   req_q;
	cpba_pkg::mem_ctl_t ctl, seq_ctl;
	cpba_pkg::rsp_t   rsp_d;

	logic [3:0]    node_count_q;
	logic [12:0]   area_pages_q;

	logic [PW-1:0] cur_q;     // page at head of current word
	logic [PW-1:0] end_q;     // area end, or release end
	logic [PW-1:0] run_q;     // free run length so far
	logic [PW-1:0] first_q;   // area start while scanning, then first page of the run
	logic [1:0]    status_q;
	logic [11:0]   fp_q;
	logic          iu_q, cr_q;
	logic          done_q;

	logic [WB-1:0] use_rd, cont_rd;
	logic          clearing;
	logic [AW-1:0] clr_addr;

	// area bounds come off one multiply, registered in S_CHECK
	logic [PW-1:0] area_start, area_end;
	assign area_start = PW'(req_q.node) * PW'(area_pages_q);
	assign area_end   = area_start + PW'(area_pages_q);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 4'd1;
			area_pages_q <= 13'd4096;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cpba_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data[3:0];
				cpba_pkg::CFG_AREA_PAGES: area_pages_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// free pages of the read word that lie inside the area
	logic [WB-1:0] free_w;
	always_comb begin
		logic [PW-1:0] p;
		for (int b = 0; b < WB; b++) begin
			p = cur_q + PW'(b);
			free_w[b] = !use_rd[b] && (p >= first_q) && (p < end_q);
		end
	end

	// free pages at the bottom of the word (continue the run so far)
	// and at the top of the word (start the run carried to the next word)
	logic [BW:0] lead_free, tail_free;
	always_comb begin
		lead_free = (BW+1)'(WB);
		for (int b = WB - 1; b >= 0; b--) begin
			if (!free_w[b]) lead_free = (BW+1)'(b);
		end
		tail_free = (BW+1)'(WB);
		for (int b = 0; b < WB; b++) begin
			if (!free_w[b]) tail_free = (BW+1)'(WB - 1 - b);
		end
	end

	// runs shorter than a word that lie wholly inside it: a window of count
	// free bits ending at each bit, built from power-of-two pieces
	logic [WB-1:0] win_end;
	always_comb begin
		logic [WB-1:0] pw;
		logic [BW-1:0] sh;
		pw = free_w;
		win_end = '1;
		for (int i = 0; i < BW; i++) begin
			sh = req_q.count[BW-1:0] & BW'((1 << i) - 1);
			if (req_q.count[i]) win_end = win_end & (pw << sh);
			pw = pw & (pw << (1 << i));
		end
	end

	logic [BW-1:0] win_pos;
	always_comb begin
		win_pos = '0;
		for (int b = WB - 1; b >= 0; b--) begin
			if (win_end[b]) win_pos = BW'(b);
		end
	end

	// per-word scan result; a run carried in from earlier words ends first
	logic [PW-1:0] need;
	logic          hit_carry, hit_win;
	logic [PW-1:0] run_n;
	logic          found;
	logic [PW-1:0] found_end;   // last page of the found run
	assign need      = PW'(req_q.count) - run_q;
	assign hit_carry = need <= PW'(lead_free);
	assign hit_win   = (req_q.count[12:BW] == '0) && (|win_end);
	assign found     = hit_carry || hit_win;
	assign found_end = hit_carry ? cur_q + need - 1'b1 : cur_q + PW'(win_pos);
	assign run_n     = (lead_free == (BW+1)'(WB)) ? run_q + PW'(WB) : PW'(tail_free);

	// word-aligned mask of the pages [first_q, end_q) within word at cur_q
	logic [WB-1:0] mark_mask, cont_mask;
	always_comb begin
		logic [PW-1:0] p;
		for (int b = 0; b < WB; b++) begin
			p = cur_q + PW'(b);
			mark_mask[b] = (p >= first_q) && (p < end_q);
			cont_mask[b] = (p != first_q);
		end
	end

	logic [PW-1:0] next_word;
	assign next_word = cur_q + PW'(WB);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpba_pkg::S_IDLE:  if (start && !busy) state_d = cpba_pkg::S_CHECK;
			cpba_pkg::S_CHECK: begin
				priority case (req_q.action)
					cpba_pkg::ACT_ACQUIRE: begin
						if (req_q.count == '0 || {1'b0, req_q.node} >= node_count_q
								|| area_end > PW'(cpba_pkg::TOTAL_PAGES)
								|| area_pages_q == '0 || area_pages_q < req_q.count)
							state_d = cpba_pkg::S_DONE;
						else
							state_d = cpba_pkg::S_READ;
					end
					cpba_pkg::ACT_RELEASE: begin
						if (req_q.count == '0
								|| PW'(req_q.page) + PW'(req_q.count) > PW'(cpba_pkg::TOTAL_PAGES))
							state_d = cpba_pkg::S_DONE;
						else
							state_d = cpba_pkg::S_MARK;
					end
					cpba_pkg::ACT_INSPECT: state_d = cpba_pkg::S_READ;
					default: state_d = cpba_pkg::S_DONE;
				endcase
			end
			cpba_pkg::S_READ: begin
				if (req_q.action == cpba_pkg::ACT_INSPECT) state_d = cpba_pkg::S_DONE;
				else state_d = cpba_pkg::S_SCAN;
			end
			cpba_pkg::S_SCAN: begin
				if (found) state_d = cpba_pkg::S_MARK;
				else if (next_word >= end_q) state_d = cpba_pkg::S_DONE;
				else state_d = cpba_pkg::S_READ;
			end
			cpba_pkg::S_MARK: if (next_word >= end_q) state_d = cpba_pkg::S_DONE;
			cpba_pkg::S_DONE: state_d = cpba_pkg::S_IDLE;
			default: state_d = cpba_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		seq_ctl = '0;
		seq_ctl.rd_addr = cur_q[BW+AW-1:BW];
		seq_ctl.wr_addr = cur_q[BW+AW-1:BW];
		seq_ctl.wr_mask = mark_mask;
		seq_ctl.cont_mask = cont_mask;
		seq_ctl.set = (req_q.action == cpba_pkg::ACT_ACQUIRE);
		unique case (state_q)
			cpba_pkg::S_READ: seq_ctl.rd_en = 1'b1;
			cpba_pkg::S_MARK: seq_ctl.wr_en = 1'b1;
			default: ;
		endcase
		if (clearing) begin
			seq_ctl.wr_en   = 1'b1;
			seq_ctl.wr_addr = clr_addr;
			seq_ctl.wr_mask = '1;
			seq_ctl.set     = 1'b0;
		end
	end
	assign ctl = seq_ctl;

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpba_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == cpba_pkg::S_DONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			cpba_pkg::S_IDLE: begin
				req_q    <= req;
				status_q <= cpba_pkg::ST_BAD;
				fp_q     <= '0;
				iu_q     <= 1'b0;
				cr_q     <= 1'b0;
				run_q    <= '0;
			end
			cpba_pkg::S_CHECK: begin
				priority case (req_q.action)
					cpba_pkg::ACT_ACQUIRE: begin
						cur_q    <= {area_start[PW-1:BW], BW'(0)};
						end_q    <= area_end;
						status_q <= (req_q.count == '0 || {1'b0, req_q.node} >= node_count_q
								|| area_end > PW'(cpba_pkg::TOTAL_PAGES))
							? cpba_pkg::ST_BAD : cpba_pkg::ST_NO_SPACE;
						first_q  <= area_start;
					end
					cpba_pkg::ACT_RELEASE: begin
						cur_q    <= PW'({req_q.page[11:BW], BW'(0)});
						first_q  <= PW'(req_q.page);
						end_q    <= PW'(req_q.page) + PW'(req_q.count);
						status_q <= cpba_pkg::ST_OK;
						if (req_q.count == '0
								|| PW'(req_q.page) + PW'(req_q.count) > PW'(cpba_pkg::TOTAL_PAGES))
							status_q <= cpba_pkg::ST_BAD;
					end
					cpba_pkg::ACT_INSPECT: begin
						cur_q    <= PW'({req_q.page[11:BW], BW'(0)});
						status_q <= cpba_pkg::ST_OK;
					end
					default: status_q <= cpba_pkg::ST_BAD;
				endcase
			end
			cpba_pkg::S_SCAN: begin
				run_q <= run_n;
				if (found) begin
					// rewind to the word holding the run's first page
					first_q  <= found_end + 1'b1 - PW'(req_q.count);
					end_q    <= found_end + 1'b1;
					cur_q    <= {found_end + 1'b1 - PW'(req_q.count)} & ~PW'(WB - 1);
					status_q <= cpba_pkg::ST_OK;
					fp_q     <= 12'(found_end + 1'b1 - PW'(req_q.count));
				end else begin
					cur_q <= next_word;
				end
			end
			cpba_pkg::S_MARK: cur_q <= next_word;
			cpba_pkg::S_DONE: begin
				if (req_q.action == cpba_pkg::ACT_INSPECT) begin
					iu_q <= use_rd[req_q.page[BW-1:0]];
					cr_q <= cont_rd[req_q.page[BW-1:0]];
				end
			end
			default: ;
		endcase
	end

	cpba_map_ram u_ram (
		.clk     (clk),
		.ctl     (ctl),
		.use_rd  (use_rd),
		.cont_rd (cont_rd)
	);

	cpba_clear_ctl u_clr (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.clr_addr (clr_addr)
	);

	always_comb begin
		rsp_d.status        = status_q;
		rsp_d.first_page    = fp_q;
		rsp_d.in_use        = iu_q;
		rsp_d.continues_run = cr_q;
	end

	assign busy = clearing || (state_q != cpba_pkg::S_IDLE) || done_q;
	assign done = done_q;
	assign rsp  = rsp_d;
endmodule

/* hdl/cpba_map_ram.sv */
module cpba_map_ram (
	input  logic                          clk,
	input  cpba_pkg::mem_ctl_t            ctl,
	output logic [cpba_pkg::WORD_BITS-1:0] use_rd,
	output logic [cpba_pkg::WORD_BITS-1:0] cont_rd
);
	// both maps in one memory word, written with per-bit enables
	logic [2*cpba_pkg::WORD_BITS-1:0] mem [cpba_pkg::TABLE_WORDS];
	logic [2*cpba_pkg::WORD_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			for (int b = 0; b < cpba_pkg::WORD_BITS; b++) begin
				if (ctl.wr_mask[b]) begin
					mem[ctl.wr_addr][b] <= ctl.set;
					mem[ctl.wr_addr][cpba_pkg::WORD_BITS+b] <= ctl.set & ctl.cont_mask[b];
				end
			end
		end
		if (ctl.rd_en) begin
			rd_q <= mem[ctl.rd_addr];
		end
	end

	assign use_rd  = rd_q[cpba_pkg::WORD_BITS-1:0];
	assign cont_rd = rd_q[2*cpba_pkg::WORD_BITS-1:cpba_pkg::WORD_BITS];
endmodule

/* hdl/cpba_clear_ctl.sv */
module cpba_clear_ctl (
	input  logic                               clk,
	input  logic                               arst_n,
	output logic                               clearing,
	output logic [cpba_pkg::ADDR_W-1:0]        clr_addr
);
	// sweep after reset so the memory reads as all free
	logic [cpba_pkg::ADDR_W:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clearing) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign clearing = (cnt_q < (cpba_pkg::ADDR_W+1)'(cpba_pkg::TABLE_WORDS));
	assign clr_addr = cnt_q[cpba_pkg::ADDR_W-1:0];
endmodule

/* hdl/cpba_checker.sv */
module cpba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input cpba_pkg::rsp_t rsp
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status != 2'd3) else $error("bad status code");
	a_fp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != cpba_pkg::ST_OK |-> rsp.first_page == '0)
		else $error("first_page set on failure");
endmodule

bind contiguous_page_bitmap_allocator_unit cpba_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

/* tb/contiguous_page_bitmap_allocator_unit_tb.sv */
module contiguous_page_bitmap_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpba_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	contiguous_page_bitmap_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// shadow page table, two bits per page (in use, continues run)
	bit page_used [TOTAL_PAGES];
	bit page_cont [TOTAL_PAGES];
	int unsigned nodes_cfg;
	int unsigned area_cfg;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int mismatches;
	int stall_cycles;
	int gap_left;
	bit no_gaps;
	bit timed_out;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// work out the result of one request and update the shadow table
	function automatic rsp_t predict_page_op(req_t r);
		rsp_t o;
		int unsigned lo, hi, run, s;
		o = '0;
		o.status = ST_BAD;
		case (r.action)
			ACT_ACQUIRE: begin
				if (r.count != 0 && r.node < nodes_cfg) begin
					lo = r.node * area_cfg;
					hi = lo + area_cfg;
					if (hi <= TOTAL_PAGES) begin
						o.status = ST_NO_SPACE;
						run = 0;
						// first fit: lowest free run that fits in the area
						for (int unsigned p = lo; p < hi; p++) begin
							if (page_used[p]) begin
								run = 0;
								continue;
							end
							run++;
							if (run == r.count) begin
								s = p + 1 - r.count;
								for (int unsigned q = s; q <= p; q++) begin
									page_used[q] = 1;
									page_cont[q] = (q != s);
								end
								o.status = ST_OK;
								o.first_page = s[11:0];
								break;
							end
						end
					end
				end
			end
			ACT_RELEASE: begin
				if (r.count != 0 && r.page + r.count <= TOTAL_PAGES) begin
					for (int unsigned q = r.page; q < r.page + r.count; q++) begin
						page_used[q] = 0;
						page_cont[q] = 0;
					end
					o.status = ST_OK;
				end
			end
			ACT_INSPECT: begin
				o.status = ST_OK;
				o.in_use = page_used[r.page];
				o.continues_run = page_cont[r.page];
			end
			default: ;
		endcase
		return o;
	endfunction

	// request driver: random gaps between items unless gaps are turned off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			req <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_rsps.push_back(predict_page_op(req));
				void'(pending_reqs.pop_front());
			end
			if (start && busy) begin
				// hold the item until it is taken
			end else if (gap_left > 0) begin
				start <= 0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > (start && !busy ? 1 : 0)) begin
				if (!no_gaps && $urandom_range(0, 5) == 0) begin
					start <= 0;
					gap_left <= $urandom_range(0, 9);
				end else begin
					start <= 1;
					req <= pending_reqs[(start && !busy) ? 1 : 0];
				end
			end else begin
				start <= 0;
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", rsp);
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status || rsp.first_page !== e.first_page ||
						rsp.in_use !== e.in_use || rsp.continues_run !== e.continues_run) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", e, rsp);
					end
				end
			end
			if (done || (start && !busy))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT)
				timed_out <= 1;
		end
	end

	task automatic add_item(logic [1:0] act, int unsigned nd, int unsigned pg, int unsigned cnt);
		req_t r;
		r.action = act;
		r.node = nd[2:0];
		r.page = pg[11:0];
		r.count = cnt[12:0];
		pending_reqs.push_back(r);
	endtask

	// waits until every item is taken and every result is back
	task automatic drain();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || start)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_NODE_COUNT)
			nodes_cfg = val & 4'hf;
		else
			area_cfg = val & 13'h1fff;
	endtask

	// random phase: mostly acquires and releases with inspects, some noise
	task automatic random_phase(int n);
		int unsigned nd, cnt, pg;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					nd = $urandom_range(0, nodes_cfg);
					cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) :
						$urandom_range(1, 80);
					add_item(ACT_ACQUIRE, nd, $urandom, cnt);
				end
				4, 5, 6: begin
					pg = $urandom_range(0, TOTAL_PAGES - 1);
					cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
						$urandom_range(1, 120);
					add_item(ACT_RELEASE, $urandom, pg, cnt);
				end
				7, 8: add_item(ACT_INSPECT, $urandom, $urandom_range(0, 4095), $urandom);
				default: add_item(2'd3, $urandom, $urandom, $urandom);
			endcase
		end
		drain();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = CFG_NODE_COUNT;
		cfg_data = '0;
		mismatches = 0;
		stall_cycles = 0;
		no_gaps = 0;
		timed_out = 0;
		nodes_cfg = 1;
		area_cfg = 4096;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		fork
			begin
				// directed: extremes and every special case
				add_item(ACT_INSPECT, 0, 0, 0);
				add_item(ACT_ACQUIRE, 0, 0, 0);
				add_item(ACT_ACQUIRE, 1, 0, 5);
				add_item(ACT_ACQUIRE, 0, 0, 4096);
				add_item(ACT_INSPECT, 0, 4095, 0);
				add_item(ACT_INSPECT, 7, 1, 8191);
				add_item(ACT_ACQUIRE, 0, 0, 1);
				add_item(ACT_RELEASE, 0, 0, 0);
				add_item(ACT_RELEASE, 0, 4095, 2);
				add_item(ACT_RELEASE, 0, 1, 4095);
				add_item(ACT_RELEASE, 0, 0, 1);
				add_item(ACT_ACQUIRE, 0, 0, 4097);
				add_item(ACT_ACQUIRE, 0, 0, 8191);
				add_item(ACT_ACQUIRE, 0, 0, 70);
				add_item(ACT_ACQUIRE, 0, 0, 60);
				add_item(ACT_RELEASE, 0, 10, 20);
				add_item(ACT_ACQUIRE, 0, 0, 15);
				add_item(ACT_INSPECT, 0, 11, 0);
				add_item(2'd3, 7, 4095, 8191);
				add_item(ACT_RELEASE, 0, 0, 4096);
				drain();
				write_reg(CFG_NODE_COUNT, 8);
				write_reg(CFG_AREA_PAGES, 512);
				add_item(ACT_ACQUIRE, 7, 0, 512);
				add_item(ACT_ACQUIRE, 7, 0, 1);
				add_item(ACT_ACQUIRE, 3, 0, 100);
				random_phase(300);
				write_reg(CFG_AREA_PAGES, 0);
				write_reg(CFG_NODE_COUNT, 15);
				random_phase(80);
				write_reg(CFG_AREA_PAGES, 8191);
				write_reg(CFG_NODE_COUNT, 1);
				random_phase(80);
				write_reg(CFG_AREA_PAGES, 4096);
				random_phase(250);
				write_reg(CFG_NODE_COUNT, 3);
				write_reg(CFG_AREA_PAGES, 1365);
				random_phase(250);
				write_reg(CFG_NODE_COUNT, 0);
				write_reg(CFG_AREA_PAGES, 1);
				random_phase(40);
				write_reg(CFG_NODE_COUNT, 8);
				write_reg(CFG_AREA_PAGES, 200);
				no_gaps = 1;
				random_phase(250);
			end
			begin
				wait (timed_out);
			end
		join_any
		if (timed_out) begin
			$display("contiguous_page_bitmap_allocator_unit test failed");
		end else if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("contiguous_page_bitmap_allocator_unit test passed");
		end else begin
			$display("contiguous_page_bitmap_allocator_unit test failed");
		end
		$finish;
	end
endmodule
